// File: sv/hic_pkg.sv
package hic_pkg;

  localparam int MaxOrderDef  = 16;
  localparam int GridOrderRst = 16;
  localparam int CfgW         = 5;
  localparam int CoordW       = 16;
  localparam int IndexW       = 32;

  typedef enum logic {
    REQ_XY2D = 1'b0,
    REQ_D2XY = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [CoordW-1:0]  coord_x;
    logic [CoordW-1:0]  coord_y;
    logic [IndexW-1:0]  curve_index;
  } hic_req_t;

  typedef struct packed {
    logic [IndexW-1:0]  out_index;
    logic [CoordW-1:0]  out_x;
    logic [CoordW-1:0]  out_y;
  } hic_res_t;

  // control that travels down the cell chain with each word
  typedef struct packed {
    logic       valid;
    req_type_e  mode;
  } hic_ctrl_t;

endpackage

// File: sv/hic_cell.sv
module hic_cell import hic_pkg::*; #(
  parameter int MAX_ORDER = MaxOrderDef,
  parameter int LVL       = 0,
  localparam int OW       = $clog2(MAX_ORDER + 1),
  localparam int CW       = MAX_ORDER,
  localparam int IW       = 2 * MAX_ORDER
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [OW-1:0]   order_i,
  input  hic_ctrl_t       ctrl_i,
  input  logic [CW-1:0]   x_i,
  input  logic [CW-1:0]   y_i,
  input  logic [IW-1:0]   d_i,
  output hic_ctrl_t       ctrl_o,
  output logic [CW-1:0]   x_o,
  output logic [CW-1:0]   y_o,
  output logic [IW-1:0]   d_o
);

  // coordinate-to-index walks from the top bit down, index-to-coordinate from bit 0 up
  localparam int            B      = MAX_ORDER - 1 - LVL;
  localparam logic [OW-1:0] B_L    = OW'(B);
  localparam logic [OW-1:0] K_L    = OW'(LVL);
  localparam logic [CW-1:0] MASK_B = {CW{1'b1}} >> (CW - B);
  localparam logic [CW-1:0] MASK_K = {CW{1'b1}} >> (CW - LVL);
  localparam logic [CW-1:0] BIT_K  = CW'(1) << LVL;

  hic_ctrl_t       ctrl_q;
  logic [CW-1:0]   x_d, x_q, y_d, y_q;
  logic [IW-1:0]   d_d, d_q;
  logic            rx, ry;

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    d_d = d_i;
    rx  = 1'b0;
    ry  = 1'b0;
    case (ctrl_i.mode)
      REQ_XY2D: begin
        if (order_i > B_L) begin
          rx = x_i[B];
          ry = y_i[B];
          d_d[2*B+1 -: 2] = {rx, rx ^ ry};
          if (!ry) begin
            x_d = rx ? (y_i ^ MASK_B) : y_i;
            y_d = rx ? (x_i ^ MASK_B) : x_i;
          end
          x_d = x_d & MASK_B;
          y_d = y_d & MASK_B;
        end
      end
      REQ_D2XY: begin
        if (order_i > K_L) begin
          rx = d_i[2*LVL+1];
          ry = d_i[2*LVL] ^ rx;
          // x and y are below 2^LVL here, so s-1-x is a flip of the low bits
          if (!ry) begin
            x_d = rx ? (y_i ^ MASK_K) : y_i;
            y_d = rx ? (x_i ^ MASK_K) : x_i;
          end
          x_d = x_d | (rx ? BIT_K : '0);
          y_d = y_d | (ry ? BIT_K : '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{valid: 1'b0, mode: REQ_XY2D};
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    d_q <= d_d;
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign d_o    = d_q;

endmodule

// File: sv/hilbert_index_convert_unit.sv
// Hilbert curve converter between (x, y) cell coordinates and curve index.
// Request channel: a word on req_i is taken at a clock edge where start_i is
// high and busy_o is low. busy_o stays low, so a request can be issued every
// cycle. req_type selects coordinates-to-index or index-to-coordinates.
// Result channel: res_o carries one word per request, valid for exactly one
// cycle while res_valid_o is high; the receiver cannot hold it off.
// Config channel: cfg_data_i holds grid_order, written when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o is always high. Orders above
// MAX_ORDER saturate to MAX_ORDER. Write it only with no request in flight.
// Each request passes through MAX_ORDER registered level cells, each of which
// handles one quadrant step, and then the output register; throughput is one
// request per cycle.
// Results leave in request order.
// Reset clears all valid bits in the chain and sets grid_order to 16
// (or MAX_ORDER if smaller); no result is shown until a request follows.
module hilbert_index_convert_unit import hic_pkg::*; #(
  parameter int MAX_ORDER = MaxOrderDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  hic_req_t         req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output hic_res_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_data_i
);

  localparam int OW        = $clog2(MAX_ORDER + 1);
  localparam int CW        = MAX_ORDER;
  localparam int IW        = 2 * MAX_ORDER;
  localparam int CEW       = CW + CoordW;
  localparam int IEW       = IW + IndexW;
  localparam int RST_ORDER = (GridOrderRst > MAX_ORDER) ? MAX_ORDER : GridOrderRst;

  logic [OW-1:0]  order_d, order_q;
  hic_ctrl_t      ctrl_s [MAX_ORDER+1];
  logic [CW-1:0]  x_s    [MAX_ORDER+1];
  logic [CW-1:0]  y_s    [MAX_ORDER+1];
  logic [IW-1:0]  d_s    [MAX_ORDER+1];
  logic [CEW-1:0] cx_ext, cy_ext, ox_ext, oy_ext;
  logic [IEW-1:0] ci_ext, od_ext;
  hic_res_t       res_d, res_q;
  logic           res_valid_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // config register, saturated on write
  always_comb begin
    order_d = order_q;
    if (cfg_valid_i && cfg_ready_o) begin
      order_d = (int'(cfg_data_i) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OW'(RST_ORDER);
    end else begin
      order_q <= order_d;
    end
  end

  // chain entry
  assign cx_ext = CEW'(req_i.coord_x);
  assign cy_ext = CEW'(req_i.coord_y);
  assign ci_ext = IEW'(req_i.curve_index);

  always_comb begin
    ctrl_s[0].valid = start_i && !busy_o;
    ctrl_s[0].mode  = req_i.req_type;
    if (req_i.req_type == REQ_XY2D) begin
      x_s[0] = cx_ext[CW-1:0];
      y_s[0] = cy_ext[CW-1:0];
      d_s[0] = '0;
    end else begin
      x_s[0] = '0;
      y_s[0] = '0;
      d_s[0] = ci_ext[IW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    hic_cell #(
      .MAX_ORDER (MAX_ORDER),
      .LVL       (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .order_i (order_q),
      .ctrl_i  (ctrl_s[k]),
      .x_i     (x_s[k]),
      .y_i     (y_s[k]),
      .d_i     (d_s[k]),
      .ctrl_o  (ctrl_s[k+1]),
      .x_o     (x_s[k+1]),
      .y_o     (y_s[k+1]),
      .d_o     (d_s[k+1])
    );
  end

  // output word, unused fields forced to zero
  assign ox_ext = CEW'(x_s[MAX_ORDER]);
  assign oy_ext = CEW'(y_s[MAX_ORDER]);
  assign od_ext = IEW'(d_s[MAX_ORDER]);

  always_comb begin
    res_d = '0;
    if (ctrl_s[MAX_ORDER].mode == REQ_XY2D) begin
      res_d.out_index = od_ext[IndexW-1:0];
    end else begin
      res_d.out_x = ox_ext[CoordW-1:0];
      res_d.out_y = oy_ext[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_s[MAX_ORDER].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_order_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (int'(cfg_data_i) > MAX_ORDER)
      |=> order_q == OW'(MAX_ORDER))
    else $error("grid order not saturated");

  a_order_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o) |=> $stable(order_q))
    else $error("grid order changed without a write");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_s[MAX_ORDER].valid && (ctrl_s[MAX_ORDER].mode == REQ_D2XY)
      |-> ((x_s[MAX_ORDER] >> order_q) == '0) && ((y_s[MAX_ORDER] >> order_q) == '0))
    else $error("coordinates exceed grid");

  a_res_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.out_index == '0) || ((res_o.out_x == '0) && (res_o.out_y == '0)))
    else $error("both result kinds nonzero");

endmodule
